### rtl/sdt_pkg.sv
// sdt_pkg: types and constants shared by the sleep deadline table.
// No dependencies; sdt_ctrl and sleep_deadline_table import it.
`timescale 1ns / 1ps

package sdt_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int ID_W      = 8;
    localparam int DELAY_W   = 24;
    localparam int TICK_W    = 32;

    typedef enum logic {
        OP_SLEEP = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_SLEEP_OK   = 2'd0,
        KIND_SLEEP_FULL = 2'd1,
        KIND_WAKE       = 2'd2,
        KIND_VERDICT    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLEEP_OUT,
        ST_SCAN,
        ST_VERDICT
    } t_state;

    typedef struct packed {
        t_op                 opcode;
        logic [ID_W-1:0]     thread_id;
        logic [DELAY_W-1:0]  delay;
        logic                machine_idle;
        logic                other_interrupts_pending;
    } t_in;

    typedef struct packed {
        t_kind               kind;
        logic [ID_W-1:0]     woken_thread;
        logic                yield_request;
        logic                timer_stop;
        logic                last;
    } t_out;

    // one table entry as held in the slot memory
    typedef struct packed {
        logic [ID_W-1:0]     thread;
        logic [TICK_W-1:0]   deadline;
    } t_entry;

endpackage

### rtl/sdt_ram.sv
// sdt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sdt_ctrl.sv
// sdt_ctrl: slot valid bits, tick counter, sweep sequencer and output register.
// Depends on sdt_pkg; drives the slot memory held in sdt_ram.
`timescale 1ns / 1ps

module sdt_ctrl import sdt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    output logic                 o_ram_we,
    output logic [IDX_W-1:0]     o_ram_waddr,
    output t_entry               o_ram_wdata,
    output logic                 o_ram_re,
    output logic [IDX_W-1:0]     o_ram_raddr,
    input  t_entry               i_ram_rdata
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    t_state              r_state, n_state;
    logic [SLOTS-1:0]    r_valid, n_valid;
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_woke, n_woke;
    logic                r_idle, n_idle;
    logic                r_pend, n_pend;
    t_kind               r_kind, n_kind;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;

    logic [IDX_W-1:0]    free_idx;
    logic                full;
    logic                out_free;
    logic                due;
    logic                quiet;
    logic [TICK_W-1:0]   diff;

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!r_valid[s]) begin
                free_idx = IDX_W'(s);
            end
        end
    end

    assign full     = &r_valid;
    assign out_free = !r_out_valid || i_out_ready;
    // wrap-safe: reached when (now - deadline) has its top bit clear
    assign diff     = r_tick - i_ram_rdata.deadline;
    assign due      = r_valid[r_idx] && !diff[TICK_W-1];
    assign quiet    = r_idle && !r_woke && !(|r_valid);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_tick      = r_tick;
        n_idx       = r_idx;
        n_woke      = r_woke;
        n_idle      = r_idle;
        n_pend      = r_pend;
        n_kind      = r_kind;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_ram_we    = 1'b0;
        o_ram_waddr = free_idx;
        o_ram_wdata = '{thread: i_in_data.thread_id,
                        deadline: r_tick + TICK_W'(i_in_data.delay)};
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.opcode == OP_SLEEP) begin
                        if (!full) begin
                            o_ram_we          = 1'b1;
                            n_valid[free_idx] = 1'b1;
                            n_kind            = KIND_SLEEP_OK;
                        end else begin
                            n_kind = KIND_SLEEP_FULL;
                        end
                        n_state = ST_SLEEP_OUT;
                    end else begin
                        n_tick   = r_tick + 1'b1;
                        n_idx    = '0;
                        n_woke   = 1'b0;
                        n_idle   = i_in_data.machine_idle;
                        n_pend   = i_in_data.other_interrupts_pending;
                        o_ram_re = 1'b1;
                        n_state  = ST_SCAN;
                    end
                end
            end
            ST_SLEEP_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{kind: r_kind, woken_thread: '0, yield_request: 1'b0,
                                    timer_stop: 1'b0, last: 1'b1};
                    n_state     = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // slot r_idx data is on the read port; stall only to emit a wake
                if (!due || out_free) begin
                    if (due) begin
                        n_out_valid    = 1'b1;
                        n_out          = '{kind: KIND_WAKE,
                                           woken_thread: i_ram_rdata.thread,
                                           yield_request: 1'b0, timer_stop: 1'b0,
                                           last: 1'b0};
                        n_valid[r_idx] = 1'b0;
                        n_woke         = 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_VERDICT;
                    end else begin
                        n_idx       = r_idx + 1'b1;
                        o_ram_re    = 1'b1;
                        o_ram_raddr = r_idx + 1'b1;
                    end
                end
            end
            ST_VERDICT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{kind: KIND_VERDICT, woken_thread: '0,
                                    yield_request: !quiet,
                                    timer_stop: quiet && !r_pend, last: 1'b1};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_woke <= n_woke;
        r_idle <= n_idle;
        r_pend <= n_pend;
        r_kind <= n_kind;
        r_out  <= n_out;
    end

endmodule

### rtl/sleep_deadline_table.sv
// sleep_deadline_table: top level; slot memory plus its sweep controller.
// Depends on sdt_pkg, sdt_ram, sdt_ctrl.
//
//   channel   signals                                     beat
//   input     i_in_valid / o_in_ready / i_in_data (t_in)    sleep request or tick
//   output    o_out_valid / i_out_ready / o_out_data (t_out) one result
//
// Sleep: accepted in ST_IDLE; the result is loaded into the output register from
// ST_SLEEP_OUT, and the input stays not ready until then.
// Tick: accepted in ST_IDLE, then ST_SCAN sweeps the slot memory (registered
// read data) one slot per cycle while no wake waits, then ST_VERDICT. A wake, the
// verdict or a sleep result waits while the output register is still full.
// One item is in work at a time.
// Reset (synchronous, active low) empties the table and zeroes the tick count.
`timescale 1ns / 1ps

module sleep_deadline_table import sdt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    t_entry           ram_rdata;

    sdt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sdt_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

endmodule
